// ----- rtl/p5f_pkg.sv -----
// p5f_pkg: shared types and helpers for the induced five-vertex path finder
// used by p5f_check, p5f_seq and the top level induced_p5_finder
package p5f_pkg;

    localparam int VERT_W = 4;
    localparam int ROW_W  = 16;
    localparam int CNT_W  = 5;

    // search depth: one level for each vertex of the path u-v-w-x-y
    typedef enum logic [2:0] {
        LVL_U,
        LVL_V,
        LVL_W,
        LVL_X,
        LVL_Y
    } t_lvl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PICK,
        S_CHECK,
        S_DONE
    } t_seq_state;

    typedef struct packed {
        logic              pass;
        logic [ROW_W-1:0]  next_cand;
        logic [ROW_W-1:0]  path;
    } t_chk;

    typedef struct packed {
        logic              found;
        logic [ROW_W-1:0]  first;
        logic [ROW_W-1:0]  cover_all;
    } t_result;

    // index of the lowest set bit, zero for an empty mask
    function automatic logic [VERT_W-1:0] low_bit(input logic [ROW_W-1:0] m);
        logic [VERT_W-1:0] idx;
        idx = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (m[i]) idx = VERT_W'(i);
        end
        return idx;
    endfunction

endpackage

// ----- rtl/p5f_ram.sv -----
// p5f_ram: generic single write port, single read port RAM with registered read
// no dependencies
module p5f_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/p5f_check.sv -----
// p5f_check: shared adjacency test unit, one candidate row checked per use
// depends on p5f_pkg
module p5f_check (
    input  p5f_pkg::t_lvl                  i_lvl,
    input  logic [p5f_pkg::ROW_W-1:0]      i_rdata,
    input  logic [p5f_pkg::ROW_W-1:0]      i_used,
    input  logic [p5f_pkg::VERT_W-1:0]     i_cur,
    input  logic [p5f_pkg::VERT_W-1:0]     i_u,
    input  logic [p5f_pkg::VERT_W-1:0]     i_v,
    input  logic [p5f_pkg::VERT_W-1:0]     i_w,
    input  logic [p5f_pkg::VERT_W-1:0]     i_x,
    output p5f_pkg::t_chk                  o_chk
);
    import p5f_pkg::*;

    logic [ROW_W-1:0] m;
    logic [ROW_W-1:0] bit_u;
    logic [ROW_W-1:0] below_u;

    // row of the candidate, limited to vertices in use, diagonal dropped
    assign m       = i_rdata & i_used & ~(ROW_W'(1) << i_cur);
    assign bit_u   = ROW_W'(1) << i_u;
    assign below_u = bit_u - ROW_W'(1);

    always_comb begin
        o_chk.path = bit_u | (ROW_W'(1) << i_v) | (ROW_W'(1) << i_w)
                   | (ROW_W'(1) << i_x) | (ROW_W'(1) << i_cur);
        unique case (i_lvl)
            LVL_U: begin
                o_chk.pass      = 1'b1;
                o_chk.next_cand = m;
            end
            LVL_V: begin
                o_chk.pass      = 1'b1;
                o_chk.next_cand = m & ~bit_u;
            end
            LVL_W: begin
                o_chk.pass      = ~m[i_u];
                o_chk.next_cand = m;
            end
            LVL_X: begin
                o_chk.pass      = ~m[i_v] & ~m[i_u];
                // end of the path must not be below u
                o_chk.next_cand = m & ~below_u;
            end
            LVL_Y: begin
                o_chk.pass      = ~m[i_w] & ~m[i_v] & ~m[i_u];
                o_chk.next_cand = '0;
            end
            default: begin
                o_chk.pass      = 1'b0;
                o_chk.next_cand = '0;
            end
        endcase
    end

endmodule

// ----- rtl/p5f_seq.sv -----
// p5f_seq: depth-first search sequencer, one candidate vertex per row read
// depends on p5f_pkg and p5f_check
module p5f_seq #(
    parameter int ROWS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [p5f_pkg::CNT_W-1:0]      i_vertex_count,
    input  logic [p5f_pkg::ROW_W-1:0]      i_rdata,
    input  logic                           i_done_ack,
    output logic [p5f_pkg::VERT_W-1:0]     o_raddr,
    output logic                           o_busy,
    output logic                           o_done,
    output p5f_pkg::t_result               o_result
);
    import p5f_pkg::*;

    t_seq_state         r_state, n_state;
    t_lvl               r_lvl, n_lvl;
    logic [VERT_W-1:0]  r_vtx [5];
    logic [VERT_W-1:0]  n_vtx [5];
    logic [ROW_W-1:0]   r_rem [5];
    logic [ROW_W-1:0]   n_rem [5];
    logic [ROW_W-1:0]   r_used, n_used;
    t_result            r_res, n_res;

    logic [CNT_W-1:0]   lim;
    logic [ROW_W:0]     used_w;
    logic [VERT_W-1:0]  pick;
    t_lvl               lvl_up;
    t_lvl               lvl_dn;
    t_chk               chk;

    assign lim    = (i_vertex_count > CNT_W'(ROWS)) ? CNT_W'(ROWS) : i_vertex_count;
    assign used_w = ((ROW_W + 1)'(1) << lim) - (ROW_W + 1)'(1);
    assign pick   = low_bit(r_rem[r_lvl]);
    assign lvl_up = t_lvl'(r_lvl + 3'd1);
    assign lvl_dn = t_lvl'(r_lvl - 3'd1);

    p5f_check u_check (
        .i_lvl   (r_lvl),
        .i_rdata (i_rdata),
        .i_used  (r_used),
        .i_cur   (r_vtx[r_lvl]),
        .i_u     (r_vtx[0]),
        .i_v     (r_vtx[1]),
        .i_w     (r_vtx[2]),
        .i_x     (r_vtx[3]),
        .o_chk   (chk)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lvl   <= LVL_U;
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
        end
        r_vtx  <= n_vtx;
        r_rem  <= n_rem;
        r_used <= n_used;
        r_res  <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_lvl   = r_lvl;
        n_vtx   = r_vtx;
        n_rem   = r_rem;
        n_used  = r_used;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_used    = used_w[ROW_W-1:0];
                    n_rem[0]  = used_w[ROW_W-1:0];
                    n_lvl     = LVL_U;
                    n_res     = '0;
                    n_state   = S_PICK;
                end
            end
            S_PICK: begin
                if (r_rem[r_lvl] == '0) begin
                    // level exhausted: back up, or finish at the outer level
                    if (r_lvl == LVL_U) begin
                        n_state = S_DONE;
                    end else begin
                        n_lvl = lvl_dn;
                    end
                end else begin
                    n_rem[r_lvl] = r_rem[r_lvl] & ~(ROW_W'(1) << pick);
                    n_vtx[r_lvl] = pick;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_PICK;
                if (chk.pass) begin
                    if (r_lvl == LVL_Y) begin
                        if (!r_res.found) begin
                            n_res.first = chk.path;
                        end
                        n_res.found     = 1'b1;
                        n_res.cover_all = r_res.cover_all | chk.path;
                    end else begin
                        n_rem[lvl_up] = chk.next_cand;
                        n_lvl         = lvl_up;
                    end
                end
            end
            S_DONE: begin
                if (i_done_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_raddr  = pick;
    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_result = r_res;

endmodule

// ----- rtl/induced_p5_finder.sv -----
// induced_p5_finder: top level, adjacency RAM, search sequencer and result register
// depends on p5f_pkg, p5f_ram, p5f_seq
//
// Usage:
//   Input channel (i_in_valid / o_in_stall): kind 0 writes row i_row_bits of
//   vertex i_row_index into the adjacency RAM and gives no result; rows at or
//   above the RAM depth are dropped. Kind 1 starts a search over the first
//   vertex_count vertices for chordless paths u-v-w-x-y with y not below u.
//   Output channel (o_out_valid / i_out_stall): one transaction per search with
//   o_found, o_first_path_mask (first path in nested ascending order) and
//   o_cover_mask (union of all such paths).
//   Configuration (i_cfg_valid / o_cfg_ready): writes vertex_count; always ready,
//   to be written only while no search is under way.
// Search steps:
//   Each candidate vertex tried at any depth takes a RAM read issued in S_PICK
//   and a check in the shared test unit in S_CHECK; each exhausted level takes
//   an S_PICK step alone; a search starts from S_IDLE and hands over in S_DONE.
//   o_in_stall stays high from search start until its result sits in the output register.
// Reset: vertex_count returns to 16, the sequencer goes idle, the output
//   register empties; RAM rows hold nothing defined until loaded.
// Stall: a finished result waits in the output register; loads are still taken,
//   and a further search runs but holds its result until the register frees up.
module induced_p5_finder #(
    parameter int VERTICES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic [3:0]                    i_row_index,
    input  logic [p5f_pkg::ROW_W-1:0]     i_row_bits,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [p5f_pkg::ROW_W-1:0]     o_first_path_mask,
    output logic [p5f_pkg::ROW_W-1:0]     o_cover_mask,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [p5f_pkg::CNT_W-1:0]     i_cfg_data
);
    import p5f_pkg::*;

    localparam int ROWS = (VERTICES < ROW_W) ? VERTICES : ROW_W;
    localparam int AW   = $clog2(ROWS);

    logic [CNT_W-1:0]   r_vertex_count;
    logic               r_out_valid;
    t_result            r_out;

    logic               in_take;
    logic               row_we;
    logic [ROW_W-1:0]   rdata;
    logic [VERT_W-1:0]  raddr;
    logic               busy;
    logic               done;
    logic               done_ack;
    t_result            result;

    assign in_take  = i_in_valid & ~o_in_stall;
    assign row_we   = in_take & ~i_kind & ({1'b0, i_row_index} < CNT_W'(ROWS));
    assign done_ack = done & (~r_out_valid | ~i_out_stall);

    p5f_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS),
        .AW    (AW)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (i_row_index[AW-1:0]),
        .i_wdata (i_row_bits),
        .i_raddr (raddr[AW-1:0]),
        .o_rdata (rdata)
    );

    p5f_seq #(
        .ROWS (ROWS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (in_take & i_kind),
        .i_vertex_count (r_vertex_count),
        .i_rdata        (rdata),
        .i_done_ack     (done_ack),
        .o_raddr        (raddr),
        .o_busy         (busy),
        .o_done         (done),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= CNT_W'(16);
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_vertex_count <= i_cfg_data;
            end
            if (done_ack) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (done_ack) begin
            r_out <= result;
        end
    end

    assign o_in_stall        = busy;
    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_out_valid;
    assign o_found           = r_out.found;
    assign o_first_path_mask = r_out.first;
    assign o_cover_mask      = r_out.cover_all;

endmodule

// ----- rtl/p5f_chk.sv -----
// p5f_chk: port-level checker for induced_p5_finder, attached by bind
// depends on p5f_pkg
module p5f_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic                          o_found,
    input  logic [p5f_pkg::ROW_W-1:0]     o_first_path_mask,
    input  logic [p5f_pkg::ROW_W-1:0]     o_cover_mask,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic                          i_kind
);

    // an empty search reports empty masks
    a_empty_masks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_first_path_mask == '0 && o_cover_mask == '0))
        else $error("result without a path carries a non-zero mask");

    // the first path is part of the cover
    a_first_in_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |->
            (o_first_path_mask != '0 && (o_first_path_mask & ~o_cover_mask) == '0))
        else $error("first path mask not inside cover mask");

    // a search transaction always takes the block out of the ready state
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_kind) |=> o_in_stall)
        else $error("search accepted but input not stalled");

    // a stalled result is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_found) && $stable(o_first_path_mask)
             && $stable(o_cover_mask)))
        else $error("stalled result changed");

endmodule

bind induced_p5_finder p5f_chk u_p5f_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_found           (o_found),
    .o_first_path_mask (o_first_path_mask),
    .o_cover_mask      (o_cover_mask),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .i_kind            (i_kind)
);
